### rtl/tac_pkg.sv
// Shared types and fixed-point constants for the thermistor temperature converter.
// No dependencies; every other file but tac_fifo refers to this package by scoped names.
`timescale 1ns / 1ps

package tac_pkg;

  // Register and field widths.
  localparam int SR_W     = 20;   // series resistor in ohms
  localparam int COEF_W   = 41;   // Steinhart-Hart coefficients, units of 2^-48
  localparam int COEF_LO  = 24;   // split point of a coefficient for partial products
  localparam int RQ_FRAC  = 20;   // fraction bits of the resistance
  localparam int LOG_FRAC = 24;   // fraction bits of the logarithms
  localparam int LOG_IT   = 24;   // squaring steps of the log2 fraction
  localparam int LZ_W     = 6;    // width of the leading-zero count and exponent
  localparam int LZ_STEPS = 6;    // binary search steps of the normalizer
  localparam int MANT_W   = 32;   // Q1.31 mantissa
  localparam int TEMP_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Logarithm and polynomial widths.
  localparam int LG2_W = LZ_W + LOG_FRAC + 1;  // signed log2 R
  localparam int MAG_W = 30;                   // |log2 R| and |ln R|
  localparam int L2_W  = 36;                   // (ln R)^2
  localparam int L3_W  = 43;                   // |ln R|^3
  localparam int L3_LO = 21;                   // split point of (ln R)^3
  localparam int BL_W  = 47;                   // B * ln R
  localparam int CL_W  = 61;                   // C * (ln R)^3
  localparam int D_W   = 63;                   // signed denominator
  localparam int QT_W  = 17;                   // quotient bits kept by the final divide
  localparam int CMP_W = 80;                   // compare width of the final divide

  localparam logic [MAG_W-1:0] LN2_Q30   = 30'd744261118;
  localparam logic [LG2_W-1:0] LOG2_OFS  = LG2_W'(20 * 16777216);
  localparam logic [D_W-1:0]   CENTI_ONE = D_W'(100) << 48;

  localparam logic [QT_W-1:0] TC_HI = 17'd57315;
  localparam logic [QT_W-1:0] TC_LO = 17'd21815;
  localparam logic [QT_W-1:0] KELVIN_OFS = 17'd27315;
  localparam logic signed [TEMP_W-1:0] T_MIN = -16'sd5500;
  localparam logic signed [TEMP_W-1:0] T_MAX = 16'sd30000;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_FULL = 2'd2,
    ST_SAT  = 2'd3
  } status_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SERIES = 2'd0,
    REG_COEF_A = 2'd1,
    REG_COEF_B = 2'd2,
    REG_COEF_C = 2'd3
  } reg_idx_t;

  // One finished result.
  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    status_t                  status;
  } result_t;

endpackage

### rtl/tac_fifo.sv
// Small register-based first-in first-out queue with full and empty flags.
// Uses no package items; DEPTH must be a power of two.
`timescale 1ns / 1ps

module tac_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW:0]      wp;
  logic [AW:0]      rp;

  // Pointers carry one extra wrap bit to tell full from empty.
  assign empty   = (wp == rp);
  assign full    = (wp[AW-1:0] == rp[AW-1:0]) && (wp[AW] != rp[AW]);
  assign rd_data = mem[rp[AW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
    end else begin
      if (wr_en && !full) wp <= wp + 1'b1;
      if (rd_en && !empty) rp <= rp + 1'b1;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (wr_en && !full) mem[wp[AW-1:0]] <= wr_data;
  end

endmodule

### rtl/tac_front.sv
// Front end: takes samples, classifies faults, forms the resistance operands.
// Depends on tac_pkg for the status codes and widths.
`timescale 1ns / 1ps

module tac_front #(
  parameter int ADC_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic [ADC_BITS-1:0]       adc_sample,
  output logic                      full,
  input  logic [tac_pkg::SR_W-1:0]  series_resistance,
  input  logic                      q_full,
  output logic                      q_wr,
  output logic [ADC_BITS+tac_pkg::SR_W+tac_pkg::RQ_FRAC-1:0] q_num,
  output logic [ADC_BITS-1:0]       q_den,
  output tac_pkg::status_t          q_cls
);

  localparam int PW = ADC_BITS + tac_pkg::SR_W;

  logic                   f_v;
  logic [PW-1:0]          f_prod;
  logic [ADC_BITS-1:0]    f_den;
  tac_pkg::status_t       f_cls;
  logic                   take;
  tac_pkg::status_t       cls;

  // The stage register frees as soon as its item moves into the queue.
  assign full = f_v && q_full;
  assign take = push && !full;
  assign q_wr = f_v;

  // Fault classification of the raw code.
  always_comb begin
    if (adc_sample == '0) cls = tac_pkg::ST_ZERO;
    else if (adc_sample == '1) cls = tac_pkg::ST_FULL;
    else cls = tac_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (take) begin
      f_v <= 1'b1;
    end else if (!q_full) begin
      f_v <= 1'b0;
    end
  end

  // Product of sample and series resistor, and the divisor full scale minus sample.
  always_ff @(posedge clk) begin
    if (take) begin
      f_prod <= PW'(adc_sample) * PW'(series_resistance);
      f_den  <= '1 - adc_sample;
      f_cls  <= cls;
    end
  end

  assign q_num = {f_prod, {tac_pkg::RQ_FRAC{1'b0}}};
  assign q_den = f_den;
  assign q_cls = f_cls;

endmodule

### rtl/tac_back.sv
// Back end: resistance division, log2 by squaring, Steinhart-Hart polynomial,
// reciprocal division and saturation, all as one stalling pipeline. Uses tac_pkg.
`timescale 1ns / 1ps

module tac_back #(
  parameter int ADC_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic [ADC_BITS+tac_pkg::SR_W+tac_pkg::RQ_FRAC-1:0] in_num,
  input  logic [ADC_BITS-1:0]           in_den,
  input  tac_pkg::status_t              in_cls,
  input  logic [tac_pkg::COEF_W-1:0]    coef_a,
  input  logic [tac_pkg::COEF_W-1:0]    coef_b,
  input  logic [tac_pkg::COEF_W-1:0]    coef_c,
  output logic                          out_valid,
  output tac_pkg::result_t              out_res
);

  localparam int NW    = ADC_BITS + tac_pkg::SR_W + tac_pkg::RQ_FRAC;
  localparam int DW    = ADC_BITS;
  localparam int LZ_W  = tac_pkg::LZ_W;
  localparam int MW    = tac_pkg::MANT_W;
  localparam int LF    = tac_pkg::LOG_FRAC;
  localparam int NIT   = tac_pkg::LOG_IT;
  localparam int MAG_W = tac_pkg::MAG_W;
  localparam int CLO   = tac_pkg::COEF_LO;
  localparam int CHI_W = tac_pkg::COEF_W - CLO;
  localparam int L2_W  = tac_pkg::L2_W;
  localparam int L3_W  = tac_pkg::L3_W;
  localparam int L3LO  = tac_pkg::L3_LO;
  localparam int L3HI_W = L3_W - L3LO;
  localparam int BL_W  = tac_pkg::BL_W;
  localparam int CL_W  = tac_pkg::CL_W;
  localparam int D_W   = tac_pkg::D_W;
  localparam int QT_W  = tac_pkg::QT_W;
  localparam int CMP_W = tac_pkg::CMP_W;
  localparam int NLZ   = tac_pkg::LZ_STEPS;

  // ---------------------------------------------------------------------------
  // Resistance: restoring division, one quotient bit per stage.
  logic             dv_v   [NW+1];
  tac_pkg::status_t dv_cls [NW+1];
  logic [DW-1:0]    dv_rem [NW+1];
  logic [NW-1:0]    dv_q   [NW+1];
  logic [DW-1:0]    dv_den [NW+1];

  assign dv_v[0]   = in_valid;
  assign dv_cls[0] = in_cls;
  assign dv_rem[0] = '0;
  assign dv_q[0]   = in_num;
  assign dv_den[0] = in_den;

  for (genvar i = 0; i < NW; i++) begin : g_rdiv
    logic [DW:0] r2;
    logic        ge;
    assign r2 = {dv_rem[i], dv_q[i][NW-1]};
    assign ge = r2 >= {1'b0, dv_den[i]};

    always_ff @(posedge clk) begin
      if (rst) dv_v[i+1] <= 1'b0;
      else if (adv) dv_v[i+1] <= dv_v[i];
    end

    // Dividend bits leave at the top while quotient bits enter at the bottom.
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_cls[i+1] <= dv_cls[i];
        dv_den[i+1] <= dv_den[i];
        dv_rem[i+1] <= ge ? DW'(r2 - {1'b0, dv_den[i]}) : r2[DW-1:0];
        dv_q[i+1]   <= {dv_q[i][NW-2:0], ge};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Normalizer: binary search for the leading one, halving the step each stage.
  logic             nz_v   [NLZ+1];
  tac_pkg::status_t nz_cls [NLZ+1];
  logic [NW-1:0]    nz_n   [NLZ+1];
  logic [LZ_W-1:0]  nz_lz  [NLZ+1];

  // A zero resistance counts as its smallest code.
  assign nz_v[0]   = dv_v[NW];
  assign nz_cls[0] = dv_cls[NW];
  assign nz_n[0]   = (dv_q[NW] == '0) ? NW'(1) : dv_q[NW];
  assign nz_lz[0]  = '0;

  for (genvar j = 0; j < NLZ; j++) begin : g_norm
    localparam int K = 32 >> j;
    logic hz;
    assign hz = (nz_n[j][NW-1 -: K] == '0);

    always_ff @(posedge clk) begin
      if (rst) nz_v[j+1] <= 1'b0;
      else if (adv) nz_v[j+1] <= nz_v[j];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        nz_cls[j+1] <= nz_cls[j];
        nz_n[j+1]   <= hz ? (nz_n[j] << K) : nz_n[j];
        nz_lz[j+1]  <= hz ? (nz_lz[j] + LZ_W'(K)) : nz_lz[j];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // log2 fraction: square the Q1.31 mantissa once per stage, one bit per stage.
  logic             lg_v    [NIT+1];
  tac_pkg::status_t lg_cls  [NIT+1];
  logic [MW-1:0]    lg_m    [NIT+1];
  logic [LF-1:0]    lg_frac [NIT+1];
  logic [LZ_W-1:0]  lg_e    [NIT+1];

  assign lg_v[0]    = nz_v[NLZ];
  assign lg_cls[0]  = nz_cls[NLZ];
  assign lg_m[0]    = nz_n[NLZ][NW-1 -: MW];
  assign lg_frac[0] = '0;
  assign lg_e[0]    = LZ_W'(NW - 1) - nz_lz[NLZ];

  for (genvar k = 0; k < NIT; k++) begin : g_log
    logic [2*MW-1:0] sq;
    logic [MW:0]     s;
    assign sq = (2*MW)'(lg_m[k]) * (2*MW)'(lg_m[k]);
    assign s  = sq[2*MW-1 -: MW+1];

    always_ff @(posedge clk) begin
      if (rst) lg_v[k+1] <= 1'b0;
      else if (adv) lg_v[k+1] <= lg_v[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        lg_cls[k+1]  <= lg_cls[k];
        lg_e[k+1]    <= lg_e[k];
        lg_m[k+1]    <= s[MW] ? s[MW:1] : s[MW-1:0];
        lg_frac[k+1] <= {lg_frac[k][LF-2:0], s[MW]};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Polynomial stages.
  logic             p1_v, p2_v, p3_v, p4_v, p5_v, p6_v, p7_v, p8_v;
  tac_pkg::status_t p1_cls, p2_cls, p3_cls, p4_cls, p5_cls, p6_cls, p7_cls, p8_cls;
  logic             p1_neg, p2_neg, p3_neg, p4_neg, p5_neg, p6_neg, p7_neg;
  logic [MAG_W-1:0] p1_mag;
  logic [MAG_W-1:0] p2_ul, p3_ul;
  logic [MAG_W+CHI_W-1:0] p3_pbh;
  logic [MAG_W+CLO-1:0]   p3_pbl;
  logic [L2_W-1:0]        p3_l2;
  logic [BL_W-1:0]        p4_bl, p5_bl, p6_bl, p7_bl;
  logic [MAG_W+L2_W-CLO-1:0] p4_qh;
  logic [MAG_W+CLO-1:0]   p4_ql;
  logic [L3_W-1:0]        p5_l3;
  logic [CHI_W+L3HI_W-1:0] p6_hh;
  logic [CHI_W+L3LO-1:0]   p6_hl;
  logic [CLO+L3HI_W-1:0]   p6_lh;
  logic [CLO+L3LO-1:0]     p6_ll;
  logic [CL_W-1:0]        p7_cl3;
  logic signed [D_W-1:0]  p8_d;

  logic signed [tac_pkg::LG2_W-1:0] log2s;
  logic [2*MAG_W-1:0]              ul_prod;
  logic [2*MAG_W-1:0]              l2_prod;
  logic [CLO+L3HI_W+L3LO:0]        cl_low;
  logic [D_W-1:0]                  d_sum;

  // Signed log2 R with the 20 fraction bits of R taken out.
  assign log2s = $signed({1'b0, lg_e[NIT], lg_frac[NIT]}) - $signed(tac_pkg::LOG2_OFS);
  assign ul_prod = (2*MAG_W)'(p1_mag) * (2*MAG_W)'(tac_pkg::LN2_Q30);
  assign l2_prod = (2*MAG_W)'(p2_ul) * (2*MAG_W)'(p2_ul);
  assign cl_low  = ((CLO+L3HI_W+L3LO+1)'(p6_lh) << L3LO) + (CLO+L3HI_W+L3LO+1)'(p6_ll);

  // Denominator A + B ln R + C (ln R)^3 with the sign of ln R on both terms.
  always_comb begin
    if (p7_neg) d_sum = D_W'(coef_a) - D_W'(p7_bl) - D_W'(p7_cl3);
    else        d_sum = D_W'(coef_a) + D_W'(p7_bl) + D_W'(p7_cl3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0; p2_v <= 1'b0; p3_v <= 1'b0; p4_v <= 1'b0;
      p5_v <= 1'b0; p6_v <= 1'b0; p7_v <= 1'b0; p8_v <= 1'b0;
    end else if (adv) begin
      p1_v <= lg_v[NIT]; p2_v <= p1_v; p3_v <= p2_v; p4_v <= p3_v;
      p5_v <= p4_v; p6_v <= p5_v; p7_v <= p6_v; p8_v <= p7_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Magnitude and sign of log2 R.
      p1_cls <= lg_cls[NIT];
      p1_neg <= log2s[tac_pkg::LG2_W-1];
      p1_mag <= log2s[tac_pkg::LG2_W-1] ? MAG_W'(-log2s) : MAG_W'(log2s);
      // Natural log magnitude.
      p2_cls <= p1_cls;
      p2_neg <= p1_neg;
      p2_ul  <= ul_prod[2*MAG_W-1 -: MAG_W];
      // Partial products of B ln R, and (ln R)^2.
      p3_cls <= p2_cls;
      p3_neg <= p2_neg;
      p3_ul  <= p2_ul;
      p3_pbh <= (MAG_W+CHI_W)'(p2_ul) * (MAG_W+CHI_W)'(coef_b[tac_pkg::COEF_W-1:CLO]);
      p3_pbl <= (MAG_W+CLO)'(p2_ul) * (MAG_W+CLO)'(coef_b[CLO-1:0]);
      p3_l2  <= l2_prod[LF +: L2_W];
      // B ln R, and partial products of (ln R)^3.
      p4_cls <= p3_cls;
      p4_neg <= p3_neg;
      p4_bl  <= BL_W'(p3_pbh) + BL_W'(p3_pbl[MAG_W+CLO-1:CLO]);
      p4_qh  <= (MAG_W+L2_W-CLO)'(p3_ul) * (MAG_W+L2_W-CLO)'(p3_l2[L2_W-1:CLO]);
      p4_ql  <= (MAG_W+CLO)'(p3_ul) * (MAG_W+CLO)'(p3_l2[CLO-1:0]);
      // (ln R)^3.
      p5_cls <= p4_cls;
      p5_neg <= p4_neg;
      p5_bl  <= p4_bl;
      p5_l3  <= L3_W'(p4_qh) + L3_W'(p4_ql[MAG_W+CLO-1:LF]);
      // Four partial products of C (ln R)^3.
      p6_cls <= p5_cls;
      p6_neg <= p5_neg;
      p6_bl  <= p5_bl;
      p6_hh  <= (CHI_W+L3HI_W)'(coef_c[tac_pkg::COEF_W-1:CLO]) *
                (CHI_W+L3HI_W)'(p5_l3[L3_W-1:L3LO]);
      p6_hl  <= (CHI_W+L3LO)'(coef_c[tac_pkg::COEF_W-1:CLO]) * (CHI_W+L3LO)'(p5_l3[L3LO-1:0]);
      p6_lh  <= (CLO+L3HI_W)'(coef_c[CLO-1:0]) * (CLO+L3HI_W)'(p5_l3[L3_W-1:L3LO]);
      p6_ll  <= (CLO+L3LO)'(coef_c[CLO-1:0]) * (CLO+L3LO)'(p5_l3[L3LO-1:0]);
      // Sum of the partials shifted down by the fraction width.
      p7_cls <= p6_cls;
      p7_neg <= p6_neg;
      p7_bl  <= p6_bl;
      p7_cl3 <= (CL_W'(p6_hh) << L3LO) + CL_W'(p6_hl) + CL_W'(cl_low >> LF);
      // Denominator.
      p8_cls <= p7_cls;
      p8_d   <= $signed(d_sum);
    end
  end

  // ---------------------------------------------------------------------------
  // Rounded reciprocal: 100 * 2^48 / D, only as many quotient bits as the range needs.
  logic             rc_v   [QT_W+1];
  tac_pkg::status_t rc_cls [QT_W+1];
  logic             rc_neg [QT_W+1];
  logic             rc_zero[QT_W+1];
  logic             rc_big [QT_W+1];
  logic [D_W-1:0]   rc_rem [QT_W+1];
  logic [D_W-2:0]   rc_ud  [QT_W+1];
  logic [QT_W-1:0]  rc_q   [QT_W+1];
  logic [D_W-2:0]   ud;
  logic [D_W-1:0]   dvd;

  assign ud  = p8_d[D_W-2:0];
  assign dvd = tac_pkg::CENTI_ONE + D_W'(ud >> 1);

  always_ff @(posedge clk) begin
    if (rst) rc_v[0] <= 1'b0;
    else if (adv) rc_v[0] <= p8_v;
  end

  // Setup stage: fault flags and the overflow test against the kept quotient width.
  always_ff @(posedge clk) begin
    if (adv) begin
      rc_cls[0]  <= p8_cls;
      rc_neg[0]  <= p8_d[D_W-1];
      rc_zero[0] <= (p8_d == '0);
      rc_big[0]  <= CMP_W'(dvd) >= (CMP_W'(ud) << QT_W);
      rc_rem[0]  <= dvd;
      rc_ud[0]   <= ud;
      rc_q[0]    <= '0;
    end
  end

  for (genvar r = 0; r < QT_W; r++) begin : g_rcp
    localparam int SH = QT_W - 1 - r;
    logic [CMP_W-1:0] sub;
    logic             ge;
    assign sub = CMP_W'(rc_ud[r]) << SH;
    assign ge  = CMP_W'(rc_rem[r]) >= sub;

    always_ff @(posedge clk) begin
      if (rst) rc_v[r+1] <= 1'b0;
      else if (adv) rc_v[r+1] <= rc_v[r];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rc_cls[r+1]  <= rc_cls[r];
        rc_neg[r+1]  <= rc_neg[r];
        rc_zero[r+1] <= rc_zero[r];
        rc_big[r+1]  <= rc_big[r];
        rc_ud[r+1]   <= rc_ud[r];
        rc_rem[r+1]  <= ge ? D_W'(CMP_W'(rc_rem[r]) - sub) : rc_rem[r];
        rc_q[r+1]    <= {rc_q[r][QT_W-2:0], ge};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Kelvin to Celsius, saturation and status.
  tac_pkg::result_t res;
  logic [QT_W-1:0]  tc;

  assign tc = rc_q[QT_W];

  always_comb begin
    res.temp   = '0;
    res.status = rc_cls[QT_W];
    if (rc_cls[QT_W] == tac_pkg::ST_OK) begin
      if (rc_neg[QT_W] || (!rc_zero[QT_W] && !rc_big[QT_W] && tc < tac_pkg::TC_LO)) begin
        res.temp   = tac_pkg::T_MIN;
        res.status = tac_pkg::ST_SAT;
      end else if (rc_zero[QT_W] || rc_big[QT_W] || tc > tac_pkg::TC_HI) begin
        res.temp   = tac_pkg::T_MAX;
        res.status = tac_pkg::ST_SAT;
      end else begin
        res.temp   = $signed(tac_pkg::TEMP_W'(tc - tac_pkg::KELVIN_OFS));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= rc_v[QT_W];
  end

  always_ff @(posedge clk) begin
    if (adv) out_res <= res;
  end

endmodule

### rtl/thermistor_adc_to_celsius_unit.sv
// Top level of the thermistor temperature converter: register file, front end,
// queues and back-end pipeline. Depends on tac_pkg, tac_fifo, tac_front and tac_back.
`timescale 1ns / 1ps

// Converts one thermistor divider code per cycle into hundredths of a degree
// Celsius with Steinhart-Hart; the sustained rate is one sample per clock while the
// output queue has room. The pipeline depth is set mostly by the one-bit-per-stage
// resistance divider (ADC_BITS + 40 stages), the 24 squaring stages of the logarithm
// and the 17 quotient stages of the reciprocal.
// The back pipeline holds whenever the output queue is full, and the front keeps
// taking samples into the middle queue until that fills too. Status 1 and 2 flag a
// code of zero or of full scale; status 3 flags a clamped temperature.

module thermistor_adc_to_celsius_unit #(
  parameter int ADC_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  // Sample queue side.
  input  logic                           push,
  output logic                           full,
  input  logic [ADC_BITS-1:0]            adc_sample,
  // Result queue side.
  input  logic                           pop,
  output logic                           empty,
  output logic signed [tac_pkg::TEMP_W-1:0] temp_centi,
  output logic [1:0]                     status,
  // Configuration writes.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tac_pkg::COEF_W-1:0]     cfg_data
);

  localparam int NW = ADC_BITS + tac_pkg::SR_W + tac_pkg::RQ_FRAC;
  localparam int MQ_W = NW + ADC_BITS + 2;
  localparam int RS_W = tac_pkg::TEMP_W + 2;

  logic [tac_pkg::SR_W-1:0]   series_resistance;
  logic [tac_pkg::COEF_W-1:0] coef_a;
  logic [tac_pkg::COEF_W-1:0] coef_b;
  logic [tac_pkg::COEF_W-1:0] coef_c;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      series_resistance <= 20'd100000;
      coef_a <= 41'd218676550000;
      coef_b <= 41'd58231180000;
      coef_c <= 41'd36031249;
    end else if (cfg_valid && cfg_ready) begin
      case (tac_pkg::reg_idx_t'(cfg_index))
        tac_pkg::REG_SERIES: series_resistance <= cfg_data[tac_pkg::SR_W-1:0];
        tac_pkg::REG_COEF_A: coef_a <= cfg_data;
        tac_pkg::REG_COEF_B: coef_b <= cfg_data;
        tac_pkg::REG_COEF_C: coef_c <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end into the middle queue.
  logic                 mq_wr, mq_full, mq_empty, mq_rd;
  logic [NW-1:0]        f_num;
  logic [ADC_BITS-1:0]  f_den;
  tac_pkg::status_t     f_cls;
  logic [MQ_W-1:0]      mq_out;

  tac_front #(.ADC_BITS(ADC_BITS)) u_front (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .adc_sample        (adc_sample),
    .full              (full),
    .series_resistance (series_resistance),
    .q_full            (mq_full),
    .q_wr              (mq_wr),
    .q_num             (f_num),
    .q_den             (f_den),
    .q_cls             (f_cls)
  );

  tac_fifo #(.WIDTH(MQ_W), .DEPTH(4)) u_midq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mq_wr),
    .wr_data ({f_num, f_den, f_cls}),
    .full    (mq_full),
    .rd_en   (mq_rd),
    .rd_data (mq_out),
    .empty   (mq_empty)
  );

  // The back pipeline moves only while the output queue has room.
  logic             adv;
  logic             bk_v;
  tac_pkg::result_t bk_res;
  logic             oq_full;
  logic [RS_W-1:0]  oq_out;
  tac_pkg::result_t oq_res;

  assign adv   = !oq_full;
  assign mq_rd = adv && !mq_empty;

  tac_back #(.ADC_BITS(ADC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (mq_rd),
    .in_num    (mq_out[MQ_W-1 -: NW]),
    .in_den    (mq_out[ADC_BITS+1:2]),
    .in_cls    (tac_pkg::status_t'(mq_out[1:0])),
    .coef_a    (coef_a),
    .coef_b    (coef_b),
    .coef_c    (coef_c),
    .out_valid (bk_v),
    .out_res   (bk_res)
  );

  tac_fifo #(.WIDTH(RS_W), .DEPTH(4)) u_outq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (bk_v && adv),
    .wr_data (bk_res),
    .full    (oq_full),
    .rd_en   (pop),
    .rd_data (oq_out),
    .empty   (empty)
  );

  assign oq_res     = tac_pkg::result_t'(oq_out);
  assign temp_centi = oq_res.temp;
  assign status     = oq_res.status;

`ifndef SYNTHESIS
  // A fault code carries a zero temperature.
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && (status == tac_pkg::ST_ZERO || status == tac_pkg::ST_FULL))
      |-> (temp_centi == '0))
    else $error("fault result with nonzero temperature");

  // A clamped result sits on one of the two limits.
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == tac_pkg::ST_SAT)
      |-> (temp_centi == tac_pkg::T_MIN || temp_centi == tac_pkg::T_MAX))
    else $error("saturated result off the limits");

  // An unclamped result lies within range.
  a_ok_range: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == tac_pkg::ST_OK)
      |-> (temp_centi >= tac_pkg::T_MIN && temp_centi <= tac_pkg::T_MAX))
    else $error("ok result out of range");

  // The back pipeline holds a finished result stable while the output queue is full.
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (bk_v && oq_full) |=> $stable(bk_res))
    else $error("back end result changed while stalled");

  // The front register holds its item while the middle queue is full.
  a_front_hold: assert property (@(posedge clk) disable iff (rst)
    (mq_wr && mq_full) |=> mq_wr)
    else $error("front item lost while middle queue full");
`endif

endmodule

### dv/thermistor_checker.sv
// Checker for the thermistor temperature converter: watches the sample, result and
// register channels, predicts each temperature and compares. Depends on tac_pkg.
`timescale 1ns / 1ps

module thermistor_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  logic                             full,
  input  logic [11:0]                      adc_sample,
  input  logic                             pop,
  input  logic                             empty,
  input  logic signed [tac_pkg::TEMP_W-1:0] temp_centi,
  input  logic [1:0]                       status,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [tac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tac_pkg::COEF_W-1:0]       cfg_data,
  output int                               fail_count,
  output int                               pending
);

  localparam logic [63:0] FULL_CODE = 64'd4095;
  localparam logic [63:0] LN2_FIX = 64'd744261118;

  // Local copy of the register file.
  logic [63:0] series_ohms, a_fix, b_fix, c_fix;

  // Temperatures still to come out, oldest first.
  tac_pkg::result_t temps_due[$];

  assign pending = temps_due.size();

  // Truncated (x * y) >> s over the full 128-bit product.
  function automatic logic [63:0] scaled_product(input logic [63:0] x, input logic [63:0] y,
                                                 input int s);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    return 64'(p >> s);
  endfunction

  // Base-2 logarithm in Q.24 of an integer of at least one.
  function automatic logic [63:0] log2_fix(input logic [63:0] x);
    int msb;
    logic [127:0] m;
    logic [63:0] frac;
    msb = 0;
    frac = 0;
    while (msb < 63 && (x >> (msb + 1)) != 0) msb++;
    m = (msb >= 31) ? 128'(x >> (msb - 31)) : 128'(x << (31 - msb));
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 128'h1_0000_0000) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return (64'(msb) << 24) | frac;
  endfunction

  // Temperature of one converter code under the current register values.
  function automatic tac_pkg::result_t celsius_of(input logic [11:0] code);
    tac_pkg::result_t r;
    logic [63:0] s, rq, mag, ul, bl, l2, l3, cl3, ud, tc;
    longint signed log2s, d, t;
    s = 64'(code);
    r.temp = '0;
    r.status = tac_pkg::ST_OK;
    if (s == 0) begin
      r.status = tac_pkg::ST_ZERO;
      return r;
    end
    if (s >= FULL_CODE) begin
      r.status = tac_pkg::ST_FULL;
      return r;
    end
    rq = ((s * series_ohms) << 20) / (FULL_CODE - s);
    if (rq == 0) rq = 1;
    log2s = longint'(log2_fix(rq)) - longint'(20 * 16777216);
    mag = (log2s < 0) ? 64'(-log2s) : 64'(log2s);
    ul = (mag * LN2_FIX) >> 30;
    bl = scaled_product(b_fix, ul, 24);
    l2 = scaled_product(ul, ul, 24);
    l3 = scaled_product(l2, ul, 24);
    cl3 = scaled_product(c_fix, l3, 24);
    d = longint'(a_fix);
    if (log2s < 0) d = d - longint'(bl) - longint'(cl3);
    else d = d + longint'(bl) + longint'(cl3);
    if (d == 0) begin
      t = 30000;
      r.status = tac_pkg::ST_SAT;
    end else if (d < 0) begin
      t = -5500;
      r.status = tac_pkg::ST_SAT;
    end else begin
      ud = 64'(d);
      tc = ((64'd100 << 48) + (ud >> 1)) / ud;
      t = longint'(tc) - 27315;
      if (t > 30000) begin
        t = 30000;
        r.status = tac_pkg::ST_SAT;
      end
      if (t < -5500) begin
        t = -5500;
        r.status = tac_pkg::ST_SAT;
      end
    end
    r.temp = 16'(t);
    return r;
  endfunction

  // Follow register writes, predict on each sample transfer, check each result transfer.
  always @(posedge clk) begin
    tac_pkg::result_t due;
    int errs;
    errs = 0;
    if (rst) begin
      series_ohms <= 64'd100000;
      a_fix <= 64'd218676550000;
      b_fix <= 64'd58231180000;
      c_fix <= 64'd36031249;
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (tac_pkg::reg_idx_t'(cfg_index))
          tac_pkg::REG_SERIES: series_ohms <= 64'(cfg_data[tac_pkg::SR_W-1:0]);
          tac_pkg::REG_COEF_A: a_fix <= 64'(cfg_data);
          tac_pkg::REG_COEF_B: b_fix <= 64'(cfg_data);
          tac_pkg::REG_COEF_C: c_fix <= 64'(cfg_data);
          default: ;
        endcase
      end
      if (push && !full) temps_due.push_back(celsius_of(adc_sample));
      if (pop && !empty) begin
        if (temps_due.size() == 0) begin
          $error("result transfer with nothing expected: temp_centi %0d status %0d",
                 temp_centi, status);
          errs++;
        end else begin
          due = temps_due.pop_front();
          if (temp_centi !== due.temp) begin
            $error("temp_centi: expected %0d, got %0d", due.temp, temp_centi);
            errs++;
          end
          if (status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, status);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

### dv/testbench.sv
// Top of the thermistor converter testbench: clock, reset, samples, register writes
// and verdict. Depends on tac_pkg, thermistor_adc_to_celsius_unit and thermistor_checker.
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [40:0] COEF_MAX = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic [11:0] adc_sample = '0;
  logic pop = 1'b0;
  logic cfg_valid = 1'b0;
  logic [tac_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tac_pkg::COEF_W-1:0] cfg_data = '0;
  logic full, empty, cfg_ready;
  logic signed [tac_pkg::TEMP_W-1:0] temp_centi;
  logic [1:0] status;
  int fail_count, pending;
  int send_idle_pct = 31;
  int take_idle_pct = 60;
  int cycles = 0;

  thermistor_adc_to_celsius_unit i_dut (
    .clk, .rst, .push, .full, .adc_sample, .pop, .empty, .temp_centi, .status,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  thermistor_checker i_checker (
    .clk, .rst, .push, .full, .adc_sample, .pop, .empty, .temp_centi, .status,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fail_count, .pending
  );

  always #5 clk = ~clk;

  // Receiver stalls at random; a watchdog bounds the run.
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= take_idle_pct);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // One sample transfer, after random idle cycles; push stays high afterward.
  task automatic send_sample(input logic [11:0] code);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    adc_sample <= code;
    @(negedge clk);
    while (full) @(negedge clk);
    @(posedge clk);
  endtask

  // Stop sending and let every outstanding temperature drain.
  task automatic drain;
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input tac_pkg::reg_idx_t idx,
                           input logic [tac_pkg::COEF_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_regs(input logic [tac_pkg::COEF_W-1:0] sr,
                           input logic [tac_pkg::COEF_W-1:0] a,
                           input logic [tac_pkg::COEF_W-1:0] b,
                           input logic [tac_pkg::COEF_W-1:0] c);
    write_reg(tac_pkg::REG_SERIES, sr);
    write_reg(tac_pkg::REG_COEF_A, a);
    write_reg(tac_pkg::REG_COEF_B, b);
    write_reg(tac_pkg::REG_COEF_C, c);
  endtask

  function automatic logic [tac_pkg::COEF_W-1:0] any_coef();
    return tac_pkg::COEF_W'({$urandom, $urandom});
  endfunction

  // Mostly interior codes, with the rails and their neighbors now and then.
  function automatic logic [11:0] any_code();
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: return 12'd0;
        1: return 12'd4095;
        2: return 12'($urandom_range(1, 3));
        default: return 12'($urandom_range(4092, 4094));
      endcase
    end
    return 12'($urandom_range(1, 4094));
  endfunction

  initial begin
    logic [11:0] edge_codes[14];
    logic [tac_pkg::COEF_W-1:0] sr, a, b, c;
    edge_codes = '{12'd0, 12'd4095, 12'd1, 12'd2, 12'd4094, 12'd4093, 12'd2048,
                   12'd2047, 12'hAAA, 12'h555, 12'hFFE, 12'h001, 12'd100, 12'd3900};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset values, then the rails and the degenerate registers.
    load_regs(41'd100000, 41'd218676550000, 41'd58231180000, 41'd36031249);
    foreach (edge_codes[i]) send_sample(edge_codes[i]);
    drain();
    // Zero resistor: the resistance falls back to its smallest code.
    load_regs(41'd0, 41'd218676550000, 41'd58231180000, 41'd36031249);
    send_sample(12'd1);
    send_sample(12'd2048);
    drain();
    // All coefficients zero: the denominator vanishes.
    load_regs(41'd1000000, 41'd0, 41'd0, 41'd0);
    send_sample(12'd2048);
    drain();
    // Tiny series resistor with a large B: the denominator goes negative at the low code.
    load_regs(41'd1, 41'd0, 41'd1 << 40, 41'd0);
    send_sample(12'd1);
    send_sample(12'd4094);
    drain();
    // Widest register values: both samples clamp at the low limit.
    load_regs(41'hFFFFF, COEF_MAX, COEF_MAX, COEF_MAX);
    send_sample(12'd1);
    send_sample(12'd4094);
    drain();

    // Random phases: realistic coefficients mostly, arbitrary ones sometimes.
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 4) begin
        send_idle_pct = 60;
        take_idle_pct = 31;
      end else if (ph == 7) begin
        send_idle_pct = 0;
        take_idle_pct = 0;
      end
      if ($urandom_range(3) != 0) begin
        sr = tac_pkg::COEF_W'($urandom_range(1000, 1000000));
        a = 41'd218676550000 + tac_pkg::COEF_W'($urandom_range(0, 1 << 30));
        b = 41'd58231180000 + tac_pkg::COEF_W'($urandom_range(0, 1 << 30));
        c = tac_pkg::COEF_W'($urandom_range(0, 100000000));
      end else begin
        sr = tac_pkg::COEF_W'($urandom_range(1, 1000000));
        a = any_coef();
        b = any_coef();
        c = any_coef();
      end
      load_regs(sr, a, b, c);
      for (int i = 0; i < 125; i++) begin
        // The sender holds off once until the pipeline has emptied.
        if (ph == 5 && i == 60) drain();
        send_sample(any_code());
      end
      drain();
    end

    repeat (150) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/tac_pkg.sv
rtl/tac_fifo.sv
rtl/tac_front.sv
rtl/tac_back.sv
rtl/thermistor_adc_to_celsius_unit.sv
dv/thermistor_checker.sv
dv/testbench.sv
